// ===== rtl/fdvc_pkg.sv =====
// Shared types, constants and helper functions of the follow-distance velocity controller.
`default_nettype none

package fdvc_pkg;

  // Default number of CORDIC iterations.
  localparam int CORDIC_STEPS_DEF = 16;

  // The CORDIC works on the position shifted left by this many guard bits.
  localparam int GUARD_BITS = 8;
  // Datapath widths: CORDIC x/y, CORDIC angle, distance, error, multiplier.
  localparam int XW = 28;
  localparam int ZW = 21;
  localparam int DW = 17;
  localparam int EW = 18;
  localparam int BW = 17;
  localparam int MW = XW + BW;

  localparam logic signed [BW-1:0] INV_GAIN_Q16 = 17'sd39797;
  localparam logic signed [ZW-1:0] PI_Q16 = 21'sd205887;

  // Operation codes of an input item.
  localparam logic [2:0] OP_FOLLOW  = 3'd0;
  localparam logic [2:0] OP_LINK    = 3'd1;
  localparam logic [2:0] OP_TRIGGER = 3'd2;
  localparam logic [2:0] OP_POS     = 3'd3;
  localparam logic [2:0] OP_SENSORS = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_TARGET_OFFSET = 3'd0;
  localparam logic [2:0] REG_MAX_RANGE     = 3'd1;
  localparam logic [2:0] REG_BAND          = 3'd2;
  localparam logic [2:0] REG_GAIN_FWD      = 3'd3;
  localparam logic [2:0] REG_GAIN_REV      = 3'd4;
  localparam logic [2:0] REG_GAIN_TURN     = 3'd5;
  localparam logic [2:0] REG_STOP_EN       = 3'd6;

  // Correction direction codes.
  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // Result of one vectoring pass, handed from the CORDIC unit to the sequencer.
  typedef struct packed {
    logic                 done;
    logic signed [XW-1:0] mag;
    logic signed [ZW-1:0] ang;
  } cordic_res_t;

  // Arctangent of 2^-i in Q16 radians, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 21'sd51472;
      5'd1:    v = 21'sd30385;
      5'd2:    v = 21'sd16055;
      5'd3:    v = 21'sd8150;
      5'd4:    v = 21'sd4091;
      5'd5:    v = 21'sd2047;
      5'd6:    v = 21'sd1024;
      5'd7:    v = 21'sd512;
      5'd8:    v = 21'sd256;
      5'd9:    v = 21'sd128;
      5'd10:   v = 21'sd64;
      5'd11:   v = 21'sd32;
      5'd12:   v = 21'sd16;
      5'd13:   v = 21'sd8;
      5'd14:   v = 21'sd4;
      5'd15:   v = 21'sd2;
      5'd16:   v = 21'sd1;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

  // Saturates a wide signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] hi;
    logic signed [MW-1:0] lo;
    logic signed [15:0]   r;
    hi = MW'(32767);
    lo = -MW'(32768);
    if (v > hi) begin
      r = 16'sh7fff;
    end else if (v < lo) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fdvc_if.sv =====
// Valid/ready channel interfaces for the input events and the drive commands.
`default_nettype none

interface fdvc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic               flag_value;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [3:0]         seen_count;

  modport source (output valid, operation, flag_value, pos_x, pos_y, seen_count,
                  input ready);
  modport sink (input valid, operation, flag_value, pos_x, pos_y, seen_count,
                output ready);
endinterface

interface fdvc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_drive;
  logic signed [15:0] angular_drive;
  logic               is_following;

  modport source (output valid, linear_drive, angular_drive, is_following,
                  input ready);
  modport sink (input valid, linear_drive, angular_drive, is_following,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/follow_distance_velocity_control.sv =====
// Top level of the follow-distance velocity controller.
`default_nettype none

// Follow-distance velocity controller. Each input transfer carries one event: set
// the follow flag, set the link flag, trigger a command, set the target position
// (signed Q4.12 metres) or set the number of sensors that see the target. Every
// event except a sensor count update, and except the unused operation codes,
// produces exactly one drive command transfer with a linear and an angular drive
// in signed Q8.8, saturated. While following and linked, an iterative CORDIC gives
// distance and bearing of the target, and a proportional law with a hysteresis
// band about the target offset sets the linear drive; the angular drive is the
// turn gain times the bearing. Otherwise the command is a stop. A sensor count
// update or an unused code returns straight to idle. An event while not
// following or not linked goes from evaluation to the done state. An event while
// following and linked waits for the CORDIC unit, which performs one iteration
// per cycle, and one shared multiplier then forms distance, linear drive and
// angular drive in turn. The block takes no new input while a command is being
// computed, but it accepts the next event while a finished command still waits
// at the output register. Configuration registers may be written at any time the
// block is idle and take effect on the next event.
module follow_distance_velocity_control
  import fdvc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fdvc_in_if.sink          in_ch,
  fdvc_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EVAL  = 4'd1;
  localparam logic [3:0] ST_CORD  = 4'd2;
  localparam logic [3:0] ST_MDIST = 4'd3;
  localparam logic [3:0] ST_ERR   = 4'd4;
  localparam logic [3:0] ST_MLIN  = 4'd5;
  localparam logic [3:0] ST_LIN   = 4'd6;
  localparam logic [3:0] ST_MANG  = 4'd7;
  localparam logic [3:0] ST_ANG   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  localparam logic signed [MW-1:0] RND_DIST = MW'(64'd8388608);
  localparam logic signed [MW-1:0] RND_LIN  = MW'(64'd2048);
  localparam logic signed [MW-1:0] RND_ANG  = MW'(64'd32768);

  // Configuration registers.
  logic [15:0] offset_r;
  logic [15:0] range_r;
  logic [15:0] band_r;
  logic [15:0] gain_fwd_r;
  logic [15:0] gain_rev_r;
  logic [15:0] gain_turn_r;
  logic        stop_en_r;

  // Controller state.
  logic               follow_r;
  logic               link_r;
  logic signed [15:0] last_x_r;
  logic signed [15:0] last_y_r;
  logic [3:0]         sensors_r;
  logic [1:0]         dir_r;
  logic signed [15:0] held_r;

  // Sequencer and working registers.
  logic [3:0]           state_r;
  logic [3:0]           state_nxt;
  logic signed [MW-1:0] mul_r;
  logic signed [EW-1:0] err_r;
  logic                 in_range_r;
  logic signed [15:0]   res_lin_r;
  logic signed [15:0]   res_ang_r;
  logic                 res_act_r;

  // Output register.
  logic               out_valid_r;
  logic signed [15:0] out_lin_r;
  logic signed [15:0] out_ang_r;
  logic               out_act_r;

  logic                 in_fire;
  logic                 out_load;
  logic                 cordic_start;
  cordic_res_t          cordic_res;
  logic signed [XW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [MW-1:0] dist_sum;
  logic [DW-1:0]        distance;
  logic                 in_range;
  logic signed [EW-1:0] err;
  logic signed [EW-1:0] band_s;
  logic [1:0]           dir_new;
  logic signed [15:0]   lin_val;
  logic signed [15:0]   ang_val;
  logic                 sensor_stop;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign cordic_start = (state_r == ST_EVAL) && follow_r && link_r;

  fdvc_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (last_x_r),
    .y_in  (last_y_r),
    .res   (cordic_res)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= 16'd2048;
      range_r     <= 16'd5734;
      band_r      <= 16'd410;
      gain_fwd_r  <= 16'd205;
      gain_rev_r  <= 16'd384;
      gain_turn_r <= 16'd2560;
      stop_en_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_OFFSET: offset_r    <= cfg_data;
        REG_MAX_RANGE:     range_r     <= cfg_data;
        REG_BAND:          band_r      <= cfg_data;
        REG_GAIN_FWD:      gain_fwd_r  <= cfg_data;
        REG_GAIN_REV:      gain_rev_r  <= cfg_data;
        REG_GAIN_TURN:     gain_turn_r <= cfg_data;
        REG_STOP_EN:       stop_en_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer. Flag, trigger and position events lead to a command; a sensor count
  // update only touches state, and it and the unused codes return to idle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.operation)
            OP_FOLLOW, OP_LINK, OP_TRIGGER, OP_POS: state_nxt = ST_EVAL;
            default:                                state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_EVAL:  state_nxt = (follow_r && link_r) ? ST_CORD : ST_DONE;
      ST_CORD:  state_nxt = cordic_res.done ? ST_MDIST : ST_CORD;
      ST_MDIST: state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_MLIN;
      ST_MLIN:  state_nxt = ST_LIN;
      ST_LIN:   state_nxt = ST_MANG;
      ST_MANG:  state_nxt = ST_ANG;
      ST_ANG:   state_nxt = ST_DONE;
      ST_DONE:  state_nxt = out_load ? ST_IDLE : ST_DONE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // The shared multiplier: distance scaling, linear gain, then turn gain.
  always_comb begin
    case (state_r)
      ST_MDIST: begin
        mul_a = cordic_res.mag;
        mul_b = INV_GAIN_Q16;
      end
      ST_MLIN: begin
        mul_a = XW'(err_r);
        mul_b = (dir_r == DIR_FWD) ? $signed({1'b0, gain_fwd_r})
                                   : $signed({1'b0, gain_rev_r});
      end
      default: begin
        mul_a = XW'(cordic_res.ang);
        mul_b = $signed({1'b0, gain_turn_r});
      end
    endcase
  end

  // Distance in Q4.12 and its error against the target offset.
  assign dist_sum = mul_r + RND_DIST;
  assign distance = dist_sum[24 +: DW];
  assign in_range = ({1'b0, range_r} >= distance);
  assign err      = $signed({1'b0, distance}) - $signed({2'b00, offset_r});
  assign band_s   = $signed({2'b00, band_r});

  // A correction starts only from idle, once the error leaves the band.
  always_comb begin
    dir_new = dir_r;
    if (dir_r != DIR_FWD && dir_r != DIR_REV) begin
      dir_new = DIR_IDLE;
      if (err > band_s) begin
        dir_new = DIR_FWD;
      end else if (err < -band_s) begin
        dir_new = DIR_REV;
      end
    end
  end

  assign lin_val     = sat16((mul_r + RND_LIN) >>> 12);
  assign ang_val     = (last_x_r == 16'sd0) ? 16'sd0 : sat16((mul_r + RND_ANG) >>> 16);
  assign sensor_stop = stop_en_r && (sensors_r == 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      follow_r  <= 1'b0;
      link_r    <= 1'b0;
      last_x_r  <= '0;
      last_y_r  <= '0;
      sensors_r <= '0;
      dir_r     <= DIR_IDLE;
      held_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        case (in_ch.operation)
          OP_FOLLOW:  follow_r  <= in_ch.flag_value;
          OP_LINK:    link_r    <= in_ch.flag_value;
          OP_POS: begin
            last_x_r <= in_ch.pos_x;
            last_y_r <= in_ch.pos_y;
          end
          OP_SENSORS: sensors_r <= in_ch.seen_count;
          default: ;
        endcase
      end
      case (state_r)
        ST_EVAL: begin
          // Without both flags the command is a stop and the held drive clears.
          if (!(follow_r && link_r)) begin
            held_r <= '0;
          end
        end
        ST_ERR: begin
          // The range test is taken from the distance formed in this cycle.
          if (in_range) begin
            dir_r <= dir_new;
          end
        end
        ST_LIN: begin
          // A zero crossing of the error ends the correction.
          if (in_range_r) begin
            if (dir_r == DIR_FWD) begin
              if (err_r <= 0) begin
                held_r <= '0;
                dir_r  <= DIR_IDLE;
              end else begin
                held_r <= lin_val;
              end
            end else if (dir_r == DIR_REV) begin
              if (err_r >= 0) begin
                held_r <= '0;
                dir_r  <= DIR_IDLE;
              end else begin
                held_r <= lin_val;
              end
            end
          end
        end
        ST_ANG: begin
          if (sensor_stop) begin
            held_r <= '0;
            dir_r  <= DIR_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_EVAL: begin
        res_lin_r <= '0;
        res_ang_r <= '0;
        res_act_r <= 1'b0;
      end
      ST_MDIST, ST_MLIN, ST_MANG: begin
        mul_r <= MW'(mul_a) * MW'(mul_b);
      end
      ST_ERR: begin
        err_r      <= err;
        in_range_r <= in_range;
      end
      ST_ANG: begin
        res_lin_r <= sensor_stop ? 16'sd0 : held_r;
        res_ang_r <= sensor_stop ? 16'sd0 : ang_val;
        res_act_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // Output register: a finished command waits here while the next event enters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lin_r <= res_lin_r;
      out_ang_r <= res_ang_r;
      out_act_r <= res_act_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.linear_drive  = out_lin_r;
  assign out_ch.angular_drive = out_ang_r;
  assign out_ch.is_following  = out_act_r;

`ifndef ASSERT_OFF
  // The correction direction never takes the unused code.
  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    dir_r != 2'd3)
    else $error("correction direction took an unused code");

  // The CORDIC unit finishes only while the sequencer waits for it.
  a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
    cordic_res.done |-> state_r == ST_CORD)
    else $error("CORDIC finished outside its wait state");

  // A sensor stop clears both drives and the direction.
  a_sensor_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ANG && sensor_stop) |=>
      (res_lin_r == 16'sd0 && res_ang_r == 16'sd0 && dir_r == DIR_IDLE))
    else $error("sensor stop left a drive or a direction");

  // A command computed without the following law is a stop.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_act_r) |-> (out_lin_r == 16'sd0 && out_ang_r == 16'sd0))
    else $error("stop command carries a nonzero drive");
`endif

endmodule

`default_nettype wire

// ===== rtl/fdvc_cordic.sv =====
// Iterative vectoring CORDIC: one shift-add-subtract step per clock cycle.
`default_nettype none

module fdvc_cordic
  import fdvc_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [15:0] x_in,
  input  wire logic signed [15:0] y_in,
  output cordic_res_t             res
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic signed [XW-1:0] cx_r;
  logic signed [XW-1:0] cy_r;
  logic signed [ZW-1:0] z_r;
  logic [IW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic signed [XW-1:0] x_ext;
  logic signed [XW-1:0] y_ext;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] step_ang;

  assign x_ext    = XW'(x_in) <<< GUARD_BITS;
  assign y_ext    = XW'(y_in) <<< GUARD_BITS;
  assign dx       = cy_r >>> cnt_r;
  assign dy       = cx_r >>> cnt_r;
  assign step_ang = atan_q16(5'(cnt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == IW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // A target behind the vehicle is first turned by half a revolution.
  always_ff @(posedge clk) begin
    if (start) begin
      if (x_in < 0) begin
        cx_r <= -x_ext;
        cy_r <= -y_ext;
        z_r  <= (y_in >= 0) ? PI_Q16 : -PI_Q16;
      end else begin
        cx_r <= x_ext;
        cy_r <= y_ext;
        z_r  <= '0;
      end
    end else if (busy_r) begin
      if (cy_r >= 0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        z_r  <= z_r + step_ang;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        z_r  <= z_r - step_ang;
      end
    end
  end

  assign res.done = done_r;
  assign res.mag  = cx_r;
  assign res.ang  = z_r;

endmodule

`default_nettype wire

// ===== dv/fdvc_checker.sv =====
// Checker that predicts every drive command of the follow controller and compares it.
module fdvc_checker
  import fdvc_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fdvc_in_if               in_mon,
  fdvc_out_if              out_mon,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               mismatches,
  output int               waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RECIP_GAIN = 39797;
  localparam longint HALF_TURN  = 205887;
  localparam longint ATAN_Q16 [24] = '{
    51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [15:0] linear;
    logic signed [15:0] angular;
    logic               following;
  } drive_cmd_t;

  drive_cmd_t expected_cmds[$];

  // Register copies, written whenever the write port fires.
  logic [15:0] offset_r, max_dist_r, band_r, gain_fwd_r, gain_rev_r, gain_turn_r;
  logic        stop_en_r;

  // Controller state.
  logic               follow_r, link_r;
  logic signed [15:0] px_r, py_r;
  logic [3:0]         seen_r;
  logic [1:0]         dir_r;
  logic signed [15:0] lin_r;

  function automatic logic signed [15:0] clip16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Applies one event to the state and works out the command it yields, if any.
  task automatic predict_cmd(input logic [2:0] op, input logic flag,
                             input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [3:0] cnt, output bit emits, output drive_cmd_t cmd);
    longint cx, cy, z, dx, dy, distance, err, lim;
    logic signed [15:0] turn;
    emits = 1'b1;
    cmd = '0;
    turn = '0;
    case (op)
      OP_FOLLOW:  follow_r = flag;
      OP_LINK:    link_r = flag;
      OP_TRIGGER: ;
      OP_POS: begin
        px_r = x;
        py_r = y;
      end
      OP_SENSORS: begin
        seen_r = cnt;
        emits = 1'b0;
      end
      default: emits = 1'b0;
    endcase
    if (emits) begin
      if (follow_r && link_r) begin
        // Vectoring pass on the guarded position; left half plane is turned by pi first.
        cx = longint'(px_r) * 256;
        cy = longint'(py_r) * 256;
        z = 0;
        if (cx < 0) begin
          z = (cy >= 0) ? HALF_TURN : -HALF_TURN;
          cx = -cx;
          cy = -cy;
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
          dx = cy >>> i;
          dy = cx >>> i;
          if (cy >= 0) begin
            cx += dx;
            cy -= dy;
            z += ATAN_Q16[i];
          end else begin
            cx -= dx;
            cy += dy;
            z -= ATAN_Q16[i];
          end
        end
        distance = (cx * RECIP_GAIN + (longint'(1) << 23)) >>> 24;
        if (distance <= longint'(max_dist_r)) begin
          err = distance - longint'(offset_r);
          lim = longint'(band_r);
          if (dir_r != DIR_FWD && dir_r != DIR_REV) begin
            dir_r = DIR_IDLE;
            if (err > lim) dir_r = DIR_FWD;
            else if (err < -lim) dir_r = DIR_REV;
          end
          if (dir_r == DIR_FWD) begin
            if (err <= 0) begin
              lin_r = '0;
              dir_r = DIR_IDLE;
            end else begin
              lin_r = clip16((longint'(gain_fwd_r) * err + 2048) >>> 12);
            end
          end else if (dir_r == DIR_REV) begin
            if (err >= 0) begin
              lin_r = '0;
              dir_r = DIR_IDLE;
            end else begin
              lin_r = clip16((longint'(gain_rev_r) * err + 2048) >>> 12);
            end
          end
        end
        if (px_r != 0) begin
          turn = clip16((longint'(gain_turn_r) * z + 32768) >>> 16);
        end
        if (stop_en_r && seen_r == 4'd0) begin
          lin_r = '0;
          turn = '0;
          dir_r = DIR_IDLE;
        end
      end else begin
        lin_r = '0;
      end
      cmd.linear = lin_r;
      cmd.angular = turn;
      cmd.following = follow_r && link_r;
    end
  endtask

  always @(posedge clk) begin
    drive_cmd_t got;
    drive_cmd_t want;
    drive_cmd_t fresh;
    bit emits;
    if (!rst_n) begin
      offset_r = 16'd2048;
      max_dist_r = 16'd5734;
      band_r = 16'd410;
      gain_fwd_r = 16'd205;
      gain_rev_r = 16'd384;
      gain_turn_r = 16'd2560;
      stop_en_r = 1'b1;
      follow_r = 1'b0;
      link_r = 1'b0;
      px_r = '0;
      py_r = '0;
      seen_r = '0;
      dir_r = DIR_IDLE;
      lin_r = '0;
      expected_cmds.delete();
      mismatches = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.linear = out_mon.linear_drive;
        got.angular = out_mon.angular_drive;
        got.following = out_mon.is_following;
        if (expected_cmds.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected command lin %0d ang %0d following %0b", $realtime,
                     got.linear, got.angular, got.following);
          end
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("%0t: command mismatch: expected lin %0d ang %0d following %0b, got lin %0d ang %0d following %0b",
                       $realtime, want.linear, want.angular, want.following,
                       got.linear, got.angular, got.following);
            end
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET_OFFSET: offset_r = cfg_data;
          REG_MAX_RANGE:     max_dist_r = cfg_data;
          REG_BAND:          band_r = cfg_data;
          REG_GAIN_FWD:      gain_fwd_r = cfg_data;
          REG_GAIN_REV:      gain_rev_r = cfg_data;
          REG_GAIN_TURN:     gain_turn_r = cfg_data;
          REG_STOP_EN:       stop_en_r = cfg_data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_cmd(in_mon.operation, in_mon.flag_value, in_mon.pos_x, in_mon.pos_y,
                    in_mon.seen_count, emits, fresh);
        if (emits) expected_cmds.push_back(fresh);
      end
    end
    waiting = expected_cmds.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top: clock, reset, event stimulus, register settings and the final verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fdvc_pkg::*;

  localparam int RANDOM_ITEMS  = 1950;
  localparam int PHASES        = 6;
  // Hold-off that leaves a good margin over the time a command takes.
  localparam int SETTLE_CYCLES = 48;
  localparam int IDLE_PCT      = 36;
  // Operation codes the block ignores.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  // While set, neither side inserts idle cycles.
  bit          calm;

  fdvc_in_if  in_ch();
  fdvc_out_if out_ch();

  follow_distance_velocity_control dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fdvc_checker u_cmd_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (fail_count),
    .waiting    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The command receiver stalls in about a third of the cycles unless calm is set.
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Offers one event and returns at the clock edge where its transfer happens. Idle
  // cycles, if any, are spent with valid low before the event is offered. The valid
  // stays high on return so back-to-back events need no extra assignment.
  task automatic send_event(input logic [2:0] op, input logic flag,
                            input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic [3:0] cnt);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.flag_value <= flag;
    in_ch.pos_x      <= x;
    in_ch.pos_y      <= y;
    in_ch.seen_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drops valid and waits until every expected command has come out. A sensor count
  // event yields no command, so a fixed hold-off follows to let the block go idle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all seven registers on consecutive cycles; the block is idle here.
  task automatic apply_setting(input logic [15:0] offset, input logic [15:0] max_dist,
                               input logic [15:0] band, input logic [15:0] k_fwd,
                               input logic [15:0] k_rev, input logic [15:0] k_turn,
                               input logic [15:0] stop_word);
    logic [2:0]  idx [7];
    logic [15:0] val [7];
    idx = '{REG_TARGET_OFFSET, REG_MAX_RANGE, REG_BAND, REG_GAIN_FWD, REG_GAIN_REV,
            REG_GAIN_TURN, REG_STOP_EN};
    val = '{offset, max_dist, band, k_fwd, k_rev, k_turn, stop_word};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random events. Most are well formed: the flags are usually switched on, and most
  // positions lie near the following distance so that the band and its hysteresis
  // are crossed often. The rest are full-range positions, stops and ignored codes.
  task automatic random_phase(input int n, input bit with_calm);
    int         done_cnt;
    int         pick;
    logic [2:0] op;
    logic       flag;
    logic signed [15:0] x, y;
    logic [3:0] cnt;
    done_cnt = 0;
    while (done_cnt < n) begin
      calm = with_calm && done_cnt >= n / 4 && done_cnt < n / 2 + n / 4;
      pick = $urandom_range(0, 99);
      // Fields an operation does not use carry random noise.
      flag = 1'($urandom());
      x    = 16'($urandom());
      y    = 16'($urandom());
      cnt  = 4'($urandom());
      if (pick < 8) begin
        op = OP_FOLLOW;
        flag = ($urandom_range(0, 99) < 85);
      end else if (pick < 16) begin
        op = OP_LINK;
        flag = ($urandom_range(0, 99) < 85);
      end else if (pick < 30) begin
        op = OP_TRIGGER;
      end else if (pick < 75) begin
        op = OP_POS;
        if ($urandom_range(0, 99) < 70) begin
          x = 16'(int'($urandom_range(0, 12000)) - 3000);
          y = 16'(int'($urandom_range(0, 6000)) - 3000);
        end
      end else if (pick < 95) begin
        op = OP_SENSORS;
        if ($urandom_range(0, 99) < 20) cnt = '0;
      end else begin
        op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end
      send_event(op, flag, x, y, cnt);
      // Ignored codes do not count toward the phase length.
      if (op <= OP_SENSORS) done_cnt++;
    end
    calm = 1'b0;
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_TRIGGER;
    in_ch.flag_value = 1'b0;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    in_ch.seen_count = '0;
    cfg_we           = 1'b0;
    cfg_index        = REG_TARGET_OFFSET;
    cfg_data         = '0;
    calm             = 1'b0;
    rst_n            = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events under the reset settings. A trigger before either flag is set
    // must give a stop, and so must following without the link.
    send_event(OP_TRIGGER, 1'b0, 16'sd0, 16'sd0, 4'd0);
    send_event(OP_FOLLOW, 1'b1, 16'sd0, 16'sd0, 4'd0);
    // Linked now, but no sensor sees the target yet, so the sensor stop applies.
    send_event(OP_LINK, 1'b1, 16'sd0, 16'sd0, 4'd0);
    send_event(OP_SENSORS, 1'b0, 16'sd0, 16'sd0, 4'd3);
    // Too far: forward correction starts, then continues.
    send_event(OP_POS, 1'b0, 16'sd4096, 16'sd0, 4'd0);
    send_event(OP_POS, 1'b0, 16'sd3000, 16'sd1000, 4'd0);
    // Crossing the offset ends the correction; inside the band the drive holds.
    send_event(OP_POS, 1'b0, 16'sd1024, 16'sd0, 4'd0);
    send_event(OP_POS, 1'b0, 16'sd2048, 16'sd300, 4'd0);
    // Too close: reverse correction, then a crossing the other way.
    send_event(OP_POS, 1'b0, 16'sd800, 16'sd0, 4'd0);
    send_event(OP_POS, 1'b0, 16'sd2100, -16'sd50, 4'd0);
    // A target straight to the side gives no angular drive.
    send_event(OP_POS, 1'b0, 16'sd0, 16'sd2000, 4'd0);
    // Targets behind the vehicle take the half-turn branch on either side.
    send_event(OP_POS, 1'b0, -16'sd4096, 16'sd0, 4'd0);
    send_event(OP_POS, 1'b0, -16'sd4096, -16'sd1, 4'd0);
    // Extreme positions lie beyond range, so the linear drive holds.
    send_event(OP_POS, 1'b0, 16'sh7fff, 16'sh7fff, 4'd0);
    send_event(OP_POS, 1'b0, 16'sh8000, 16'sh8000, 4'd0);
    send_event(OP_POS, 1'b0, 16'sh8000, 16'sd0, 4'd0);
    send_event(OP_POS, 1'b0, 16'sh7fff, 16'sh8000, 4'd0);
    send_event(OP_SENSORS, 1'b1, 16'sh7fff, 16'sh7fff, 4'd0);
    send_event(OP_TRIGGER, 1'b0, 16'sd0, 16'sd0, 4'd0);
    send_event(OP_SENSORS, 1'b0, 16'sd0, 16'sd0, 4'd15);
    // Unused codes are dropped without a command.
    send_event(OP_UNUSED_LO, 1'b1, 16'sh7fff, 16'sh8000, 4'd15);
    send_event(3'd6, 1'b0, 16'sd0, 16'sd0, 4'd0);
    send_event(OP_UNUSED_HI, 1'b1, -16'sd1, -16'sd1, 4'd15);
    send_event(OP_LINK, 1'b0, 16'sd0, 16'sd0, 4'd0);
    send_event(OP_LINK, 1'b1, 16'sd0, 16'sd0, 4'd0);
    send_event(OP_FOLLOW, 1'b0, 16'sd0, 16'sd0, 4'd0);
    send_event(OP_FOLLOW, 1'b1, 16'sd0, 16'sd0, 4'd0);

    // Random phases, each under its own register setting. The first keeps the reset
    // values; one phase has a long stretch where neither side idles.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: apply_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                           16'hffff);
          2: apply_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                           16'h0000);
          3: apply_setting(16'($urandom_range(0, 8191)), 16'($urandom_range(2000, 12000)),
                           16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1023)),
                           16'($urandom_range(0, 1023)), 16'($urandom()),
                           16'($urandom()) & 16'hfffe);
          4: apply_setting(16'($urandom_range(0, 512)), 16'hffff,
                           16'($urandom_range(0, 64)), 16'($urandom_range(16384, 65535)),
                           16'($urandom_range(16384, 65535)),
                           16'($urandom_range(16384, 65535)), 16'($urandom()) | 16'h0001);
          default: apply_setting(16'd2048, 16'd5734, 16'd410, 16'd205, 16'd384, 16'd2560,
                                 16'd1);
        endcase
      end
      random_phase(RANDOM_ITEMS / PHASES, p == 3);
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
